// File: hdl/gai_pkg.sv
// Package for the gyro angle integrator: field widths, tone and LED codes,
// modulo constants and the lane control struct. No dependencies.
package gai_pkg;

    localparam int TIME_W   = 32;
    localparam int RATE_W   = 16;
    localparam int TICK_W   = 16;
    localparam int ANGLE_W  = 26;
    localparam int TONE_W   = 2;
    localparam int LED_W    = 4;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // Tone codes
    localparam logic [TONE_W-1:0] TONE_SILENT = 2'd0;
    localparam logic [TONE_W-1:0] TONE_DO     = 2'd1;
    localparam logic [TONE_W-1:0] TONE_RE     = 2'd2;
    localparam logic [TONE_W-1:0] TONE_MI     = 2'd3;

    // LED patterns
    localparam logic [LED_W-1:0] LED_OFF = 4'b0000;
    localparam logic [LED_W-1:0] LED_DO  = 4'b0001;
    localparam logic [LED_W-1:0] LED_RE  = 4'b0010;
    localparam logic [LED_W-1:0] LED_MI  = 4'b0100;
    localparam logic [LED_W-1:0] LED_ALL = 4'b1111;

    // Band edges of |z angle| in whole degrees
    localparam int BAND_DO_HI = 20;
    localparam int BAND_RE_LO = 35;
    localparam int BAND_RE_HI = 55;
    localparam int BAND_MI_LO = 70;
    localparam int BAND_MI_HI = 90;

    // 360 = 8 * 45, and 2^12 is 1 mod 45, so 12-bit chunks fold mod 45
    localparam int CHUNK_W   = 12;
    localparam int MOD_DIV   = 45;
    localparam int MOD_W     = 6;
    localparam int MOD_STEPS = 7;
    localparam int OCT_W     = 3;

    typedef struct packed {
        logic start;
        logic integ;
    } lane_ctl_t;

endpackage

// File: hdl/gai_if.sv
// Valid/ready channel interfaces for sensor records and angle results.
// Depends on gai_pkg.
interface gai_sample_if;
    import gai_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [TIME_W-1:0]        time_stamp;
    logic signed [RATE_W-1:0] gyro_x;
    logic signed [RATE_W-1:0] gyro_y;
    logic signed [RATE_W-1:0] gyro_z;
    logic                     switch_level;

    modport source (output valid, time_stamp, gyro_x, gyro_y, gyro_z, switch_level,
                    input ready);
    modport sink   (input valid, time_stamp, gyro_x, gyro_y, gyro_z, switch_level,
                    output ready);
endinterface

interface gai_result_if;
    import gai_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] angle_x;
    logic signed [ANGLE_W-1:0] angle_y;
    logic signed [ANGLE_W-1:0] angle_z;
    logic [TONE_W-1:0]         tone_code;
    logic [LED_W-1:0]          led_mask;

    modport source (output valid, angle_x, angle_y, angle_z, tone_code, led_mask,
                    input ready);
    modport sink   (input valid, angle_x, angle_y, angle_z, tone_code, led_mask,
                    output ready);
endinterface

// File: hdl/gyro_angle_integrator.sv
// Gyro angle integrator: three integrating lanes plus a tone/LED merge stage.
// One sample is processed at a time: the 8-stage lane pipeline holds a single record
// in flight, and a finished result waits in the output register while the next
// sample is taken. Reset (rst_n, async, active low) clears angles, rates, the held
// tone and the started flag; the first sample only captures its time.
module gyro_angle_integrator #(
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    gai_sample_if.sink    sample,
    gai_result_if.source  result
);
    import gai_pkg::*;

    localparam int ACC_W = FRAC_BITS + 10;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_RUN,
        S_HOLD
    } state_t;

    state_t                    state_reg;
    logic                      started_reg;
    logic [TIME_W-1:0]         time_reg;
    logic [TIME_W-1:0]         diff_reg;
    logic                      integ_reg;
    logic signed [RATE_W-1:0]  gx_reg;
    logic signed [RATE_W-1:0]  gy_reg;
    logic signed [RATE_W-1:0]  gz_reg;
    logic                      sw_reg;

    logic                      out_valid_reg;
    logic signed [ANGLE_W-1:0] ax_reg;
    logic signed [ANGLE_W-1:0] ay_reg;
    logic signed [ANGLE_W-1:0] az_reg;
    logic [TONE_W-1:0]         tone_reg;
    logic [LED_W-1:0]          led_reg;

    logic                      accept;
    logic                      out_free;
    logic                      load_out;
    logic [TIME_W-1:0]         dabs;
    logic [TICK_W-1:0]         ticks;
    lane_ctl_t                 ctl;
    logic [2:0]                lane_done;
    logic signed [ACC_W-1:0]   acc_x;
    logic signed [ACC_W-1:0]   acc_y;
    logic signed [ACC_W-1:0]   acc_z;
    logic [TONE_W-1:0]         tone_next;
    logic [LED_W-1:0]          led_next;

    // Take a sample beat only when no record is in flight
    assign sample.ready = (state_reg == S_IDLE);
    assign accept       = sample.valid && sample.ready;

    // The output register is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || result.ready;
    assign load_out = ((state_reg == S_RUN) && lane_done[0] && out_free) ||
                      ((state_reg == S_HOLD) && out_free);

    // Tick distance: magnitude of the wrapped difference, saturated to 16 bits
    assign dabs  = diff_reg[TIME_W-1] ? -diff_reg : diff_reg;
    assign ticks = (|dabs[TIME_W-1:TICK_W]) ? TICK_MAX : dabs[TICK_W-1:0];

    assign ctl.start = (state_reg == S_TICK);
    assign ctl.integ = integ_reg;

    gai_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .rate  (gx_reg),
        .ticks (ticks),
        .done  (lane_done[0]),
        .angle (acc_x)
    );

    gai_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .rate  (gy_reg),
        .ticks (ticks),
        .done  (lane_done[1]),
        .angle (acc_y)
    );

    gai_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .rate  (gz_reg),
        .ticks (ticks),
        .done  (lane_done[2]),
        .angle (acc_z)
    );

    // Tone and LEDs follow the z angle; the held tone advances on each result
    gai_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load_out),
        .switch_level (sw_reg),
        .angle_z      (acc_z),
        .tone_code    (tone_next),
        .led_mask     (led_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            started_reg   <= 1'b0;
            time_reg      <= '0;
            diff_reg      <= '0;
            integ_reg     <= 1'b0;
            gx_reg        <= '0;
            gy_reg        <= '0;
            gz_reg        <= '0;
            sw_reg        <= 1'b1;
            out_valid_reg <= 1'b0;
            ax_reg        <= '0;
            ay_reg        <= '0;
            az_reg        <= '0;
            tone_reg      <= TONE_SILENT;
            led_reg       <= LED_OFF;
        end
        else
        begin
            // Capture the sample; the first one only sets the time base
            if (accept)
            begin
                diff_reg    <= sample.time_stamp - time_reg;
                integ_reg   <= started_reg && (sample.time_stamp != time_reg);
                time_reg    <= sample.time_stamp;
                started_reg <= 1'b1;
                gx_reg      <= sample.gyro_x;
                gy_reg      <= sample.gyro_y;
                gz_reg      <= sample.gyro_z;
                sw_reg      <= sample.switch_level;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_TICK;
                    end
                end
                S_TICK:
                begin
                    state_reg <= S_RUN;
                end
                S_RUN:
                begin
                    if (lane_done[0])
                    begin
                        state_reg <= out_free ? S_IDLE : S_HOLD;
                    end
                end
                S_HOLD:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Load the result beat, or drop it once taken
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                ax_reg        <= ANGLE_W'(acc_x);
                ay_reg        <= ANGLE_W'(acc_y);
                az_reg        <= ANGLE_W'(acc_z);
                tone_reg      <= tone_next;
                led_reg       <= led_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.angle_x   = ax_reg;
    assign result.angle_y   = ay_reg;
    assign result.angle_z   = az_reg;
    assign result.tone_code = tone_reg;
    assign result.led_mask  = led_reg;

endmodule

// File: hdl/gai_lane.sv
// One axis lane: trapezoidal increment, accumulate, signed modulo 360 degrees.
// Depends on gai_pkg.
module gai_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  gai_pkg::lane_ctl_t               ctl,
    input  logic signed [gai_pkg::RATE_W-1:0] rate,
    input  logic [gai_pkg::TICK_W-1:0]       ticks,
    output logic                             done,
    output logic signed [FRAC_BITS+9:0]      angle
);
    import gai_pkg::*;

    localparam int ACC_W  = FRAC_BITS + 10;
    localparam int RS_W   = RATE_W + 1;
    localparam int PROD_W = RS_W + TICK_W;
    localparam int PMAG_W = PROD_W - 1;
    localparam int BASE_W = PMAG_W + 4;
    localparam int SH_UP  = (FRAC_BITS >= 15) ? FRAC_BITS - 15 : 0;
    localparam int SH_DN  = (FRAC_BITS < 15) ? 15 - FRAC_BITS : 0;
    localparam int INC_W  = BASE_W + SH_UP;
    localparam int SUM_W  = INC_W + 2;
    localparam int MAG_W  = SUM_W - 1;
    localparam int Q_W    = MAG_W - FRAC_BITS - OCT_W;
    localparam int NCH    = (Q_W + CHUNK_W - 1) / CHUNK_W;
    localparam int CS_W   = CHUNK_W + $clog2(NCH + 1);
    localparam int FOLD_W = CHUNK_W + 1;
    localparam int STAGES = 8;

    logic [STAGES-1:0]         vl_reg;
    logic                      integ_reg;
    logic signed [RATE_W-1:0]  last_rate_reg;
    logic signed [ACC_W-1:0]   acc_reg;

    logic signed [RS_W-1:0]    rs_reg;
    logic [TICK_W-1:0]         tk_reg;
    logic signed [RATE_W-1:0]  rate_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [PMAG_W-1:0]         pm_reg;
    logic                      pneg_reg;
    logic [INC_W-1:0]          inc_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [CS_W-1:0]           csum_reg;
    logic [OCT_W-1:0]          oct_reg;
    logic [FRAC_BITS-1:0]      lo_reg;
    logic                      sneg_reg;
    logic [MOD_W-1:0]          r45_reg;

    logic signed [PROD_W-1:0]  rs_ext;
    logic signed [PROD_W-1:0]  tk_ext;
    logic signed [PROD_W-1:0]  prod_next;
    logic [PROD_W-1:0]         pabs;
    logic [BASE_W-1:0]         base;
    logic [INC_W-1:0]          inc_next;
    logic signed [SUM_W-1:0]   acc_s;
    logic signed [SUM_W-1:0]   inc_s;
    logic signed [SUM_W-1:0]   sum_next;
    logic [SUM_W-1:0]          sabs;
    logic [MAG_W-1:0]          mag;
    logic [NCH*CHUNK_W-1:0]    qpad;
    logic [CS_W-1:0]           csum_next;
    logic [FOLD_W-1:0]         rem;
    logic [ACC_W-2:0]          mag_new;
    logic signed [ACC_W-1:0]   acc_next;

    // Multiply rate sum by ticks
    assign rs_ext    = PROD_W'(rs_reg);
    assign tk_ext    = PROD_W'(signed'({1'b0, tk_reg}));
    assign prod_next = rs_ext * tk_ext;

    // Magnitude, times ten, scale to the fraction
    assign pabs     = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign base     = (BASE_W'(pm_reg) << 3) + (BASE_W'(pm_reg) << 1);
    assign inc_next = INC_W'(base >> SH_DN) << SH_UP;

    // Accumulate
    assign acc_s    = SUM_W'(acc_reg);
    assign inc_s    = signed'(SUM_W'(inc_reg));
    assign sum_next = pneg_reg ? acc_s - inc_s : acc_s + inc_s;

    // Split magnitude: fraction, low three bits of degrees, rest folded mod 45
    assign sabs = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign mag  = sabs[MAG_W-1:0];
    assign qpad = (NCH*CHUNK_W)'(mag[MAG_W-1:FRAC_BITS+OCT_W]);

    always_comb
    begin
        csum_next = '0;
        for (int i = 0; i < NCH; i++)
        begin
            csum_next = csum_next + CS_W'(qpad[i*CHUNK_W +: CHUNK_W]);
        end
    end

    // Restoring reduction of the folded chunk sum
    always_comb
    begin
        rem = FOLD_W'(csum_reg[CHUNK_W-1:0]) + FOLD_W'(csum_reg[CS_W-1:CHUNK_W]);
        for (int k = MOD_STEPS - 1; k >= 0; k--)
        begin
            if (rem >= FOLD_W'(MOD_DIV << k))
            begin
                rem = rem - FOLD_W'(MOD_DIV << k);
            end
        end
    end

    // Rebuild the reduced angle and restore its sign
    assign mag_new  = {r45_reg, oct_reg, lo_reg};
    assign acc_next = sneg_reg ? -signed'({1'b0, mag_new}) : signed'({1'b0, mag_new});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vl_reg        <= '0;
            integ_reg     <= 1'b0;
            last_rate_reg <= '0;
            acc_reg       <= '0;
        end
        else
        begin
            vl_reg <= {vl_reg[STAGES-2:0], ctl.start};
            if (ctl.start)
            begin
                integ_reg <= ctl.integ;
            end
            if (vl_reg[STAGES-2] && integ_reg)
            begin
                acc_reg       <= acc_next;
                last_rate_reg <= rate_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rs_reg   <= RS_W'(last_rate_reg) + RS_W'(rate);
            tk_reg   <= ticks;
            rate_reg <= rate;
        end
        if (vl_reg[0])
        begin
            prod_reg <= prod_next;
        end
        if (vl_reg[1])
        begin
            pm_reg   <= pabs[PMAG_W-1:0];
            pneg_reg <= prod_reg[PROD_W-1];
        end
        if (vl_reg[2])
        begin
            inc_reg <= inc_next;
        end
        if (vl_reg[3])
        begin
            sum_reg <= sum_next;
        end
        if (vl_reg[4])
        begin
            csum_reg <= csum_next;
            oct_reg  <= mag[FRAC_BITS+OCT_W-1:FRAC_BITS];
            lo_reg   <= mag[FRAC_BITS-1:0];
            sneg_reg <= sum_reg[SUM_W-1];
        end
        if (vl_reg[5])
        begin
            r45_reg <= rem[MOD_W-1:0];
        end
    end

    assign done  = vl_reg[STAGES-1];
    assign angle = acc_reg;

endmodule

// File: hdl/gai_merge.sv
// Merge stage: picks tone code and LED mask from the z lane and holds the tone.
// Depends on gai_pkg.
module gai_merge #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic                          switch_level,
    input  logic signed [FRAC_BITS+9:0]   angle_z,
    output logic [gai_pkg::TONE_W-1:0]    tone_code,
    output logic [gai_pkg::LED_W-1:0]     led_mask
);
    import gai_pkg::*;

    localparam int ACC_W = FRAC_BITS + 10;
    localparam logic [ACC_W-1:0] LIM_DO_HI = ACC_W'(BAND_DO_HI) << FRAC_BITS;
    localparam logic [ACC_W-1:0] LIM_RE_LO = ACC_W'(BAND_RE_LO) << FRAC_BITS;
    localparam logic [ACC_W-1:0] LIM_RE_HI = ACC_W'(BAND_RE_HI) << FRAC_BITS;
    localparam logic [ACC_W-1:0] LIM_MI_LO = ACC_W'(BAND_MI_LO) << FRAC_BITS;
    localparam logic [ACC_W-1:0] LIM_MI_HI = ACC_W'(BAND_MI_HI) << FRAC_BITS;

    logic [TONE_W-1:0] held_tone_reg;
    logic [ACC_W-1:0]  mz;

    assign mz = angle_z[ACC_W-1] ? ACC_W'(-angle_z) : ACC_W'(angle_z);

    always_comb
    begin
        if (switch_level)
        begin
            tone_code = TONE_SILENT;
            led_mask  = LED_OFF;
        end
        else if (mz < LIM_DO_HI)
        begin
            tone_code = TONE_DO;
            led_mask  = LED_DO;
        end
        else if (mz >= LIM_RE_LO && mz < LIM_RE_HI)
        begin
            tone_code = TONE_RE;
            led_mask  = LED_RE;
        end
        else if (mz >= LIM_MI_LO && mz < LIM_MI_HI)
        begin
            tone_code = TONE_MI;
            led_mask  = LED_MI;
        end
        else
        begin
            tone_code = held_tone_reg;
            led_mask  = LED_ALL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_tone_reg <= TONE_SILENT;
        end
        else if (load)
        begin
            held_tone_reg <= tone_code;
        end
    end

endmodule

// File: hdl/gai_checker.sv
// Port-level checks for the gyro angle integrator, bound to the top level.
// Depends on gai_pkg and gyro_angle_integrator.
module gai_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            sample_valid,
    input logic                            sample_ready,
    input logic                            result_valid,
    input logic                            result_ready,
    input logic [gai_pkg::ANGLE_W-1:0]     angle_x,
    input logic [gai_pkg::TONE_W-1:0]      tone_code,
    input logic [gai_pkg::LED_W-1:0]       led_mask
);
    import gai_pkg::*;

    logic [1:0] pend_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = sample_valid && sample_ready;
    assign out_acc = result_valid && result_ready;

    // Track records accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 2'(in_acc) - 2'(out_acc);
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(angle_x) && $stable(tone_code) && $stable(led_mask))
        else $error("result beat changed while stalled");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pend_reg != 2'd0)
        else $error("result beat without a pending sample");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == 2'd2 |-> !sample_ready)
        else $error("sample taken with two records outstanding");

    a_tone_led: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            (led_mask == LED_OFF && tone_code == TONE_SILENT) ||
            (led_mask == LED_DO && tone_code == TONE_DO) ||
            (led_mask == LED_RE && tone_code == TONE_RE) ||
            (led_mask == LED_MI && tone_code == TONE_MI) ||
            (led_mask == LED_ALL))
        else $error("tone code does not match LED mask");

endmodule

bind gyro_angle_integrator gai_checker u_gai_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .angle_x      (result.angle_x),
    .tone_code    (result.tone_code),
    .led_mask     (result.led_mask)
);
